// ----- design/abkf_pkg.sv -----
// Package for the angle/bias Kalman filter: formats, register indexes and
// saturation helpers. No dependencies.
`default_nettype none
package abkf_pkg;
   localparam int ValBits = 32;
   localparam int CovBits = 48;
   localparam int DtBits  = 16;
   localparam int CsrIdxBits = 2;

   typedef logic signed [ValBits-1:0] val_type;
   typedef logic signed [CovBits-1:0] cov_type;
   typedef logic [DtBits-1:0] dt_type;
   typedef logic [31:0] noise_type;

   typedef enum logic [CsrIdxBits-1:0] {
      CSR_ANGLE_Q = 2'd0,
      CSR_BIAS_Q  = 2'd1,
      CSR_MEAS_R  = 2'd2,
      CSR_UNUSED  = 2'd3
   } csr_idx_type;

   // Saturate a wide signed value to 48 bits.
   function automatic cov_type sat_cov(input logic signed [127:0] v);
      if (v > 128'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
      if (v < -128'sh8000_0000_0000) return 48'sh8000_0000_0000;
      return v[CovBits-1:0];
   endfunction

   function automatic val_type sat_val(input logic signed [127:0] v);
      if (v > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -128'sh8000_0000) return 32'sh8000_0000;
      return v[ValBits-1:0];
   endfunction
endpackage
`default_nettype wire

// ----- design/abkf_if.sv -----
// Valid/ready channel interfaces for the angle/bias Kalman filter.
// Depends on abkf_pkg.
`default_nettype none
interface abkf_req_if;
   import abkf_pkg::*;
   logic    valid;
   logic    ready;
   val_type measured_angle;
   val_type measured_rate;
   dt_type  time_step;
   modport source (output valid, measured_angle, measured_rate, time_step, input ready);
   modport sink   (input valid, measured_angle, measured_rate, time_step, output ready);
endinterface

interface abkf_rsp_if;
   import abkf_pkg::*;
   logic    valid;
   logic    ready;
   val_type filtered_angle;
   modport source (output valid, filtered_angle, input ready);
   modport sink   (input valid, filtered_angle, output ready);
endinterface

interface abkf_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/abkf_mul.sv -----
// Sequential signed multiplier: one multiplicand bit per cycle, product
// shifted right and saturated by the caller. Depends on abkf_pkg.
`default_nettype none
module abkf_mul (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic signed [47:0]  op_a,
   input  wire logic signed [47:0]  op_b,
   output logic                     done,
   output logic signed [96:0]       product
);
   import abkf_pkg::*;
   logic [47:0] a_ff, a_in;
   logic [96:0] acc_ff, acc_in;
   logic [47:0] bmag_ff, bmag_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;

   always_comb begin
      a_in = a_ff; acc_in = acc_ff; bmag_in = bmag_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      if (start) begin
         a_in = op_a[47] ? 48'(-op_a) : op_a;
         bmag_in = op_b[47] ? 48'(-op_b) : op_b;
         neg_in = op_a[47] ^ op_b[47];
         acc_in = '0; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         // add one shifted partial product per cycle
         if (a_ff[0]) acc_in = acc_ff + (97'(bmag_ff) << cnt_ff);
         a_in = a_ff >> 1;
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      a_ff <= a_in; acc_ff <= acc_in; bmag_ff <= bmag_in; neg_ff <= neg_in;
   end

   assign done = busy_ff && cnt_ff == 6'd47;
   // sign-magnitude result; caller shifts magnitude then applies sign
   assign product = {neg_ff, acc_in[95:0]};
endmodule
`default_nettype wire

// ----- design/abkf_div.sv -----
// Restoring divider, one quotient bit per cycle, for (num << 32) / den.
// Depends on abkf_pkg.
`default_nettype none
module abkf_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [47:0] num,
   input  wire logic signed [48:0] den,
   output logic                    done,
   output logic signed [47:0]      quot
);
   import abkf_pkg::*;
   logic [79:0] n_ff, n_in;
   logic [48:0] d_ff, d_in;
   logic [49:0] rem_ff, rem_in;
   logic [79:0] q_ff, q_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [49:0] trial;

   always_comb begin
      n_in = n_ff; d_in = d_ff; rem_in = rem_ff; q_in = q_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {rem_ff[48:0], n_ff[79]};
      if (start) begin
         n_in = {(num[47] ? 48'(-num) : num), 32'd0};
         d_in = den[48] ? 49'(-den) : den;
         neg_in = num[47] ^ den[48];
         rem_in = '0; q_in = '0; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = n_ff << 1;
         if (trial >= {1'b0, d_ff}) begin
            rem_in = trial - {1'b0, d_ff}; q_in = {q_ff[78:0], 1'b1};
         end else begin
            rem_in = trial; q_in = {q_ff[78:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd79) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      n_ff <= n_in; d_ff <= d_in; rem_ff <= rem_in; q_ff <= q_in; neg_ff <= neg_in;
   end

   assign done = busy_ff && cnt_ff == 7'd79;
   always_comb begin
      if (q_in[79:47] != '0 && !(neg_ff && q_in[79:0] == 80'h8000_0000_0000))
         quot = neg_ff ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
      else
         quot = neg_ff ? 48'(-q_in[47:0]) : q_in[47:0];
   end
endmodule
`default_nettype wire

// ----- design/angle_bias_kalman_filter.sv -----
// Two-state angle/bias Kalman filter with serial multiply and divide units.
// Each accepted word runs through 10 multiplies and 2 divides (the divides are
// skipped when the variance is zero), then an output state. One word in flight;
// the next word is taken once the filter is back in idle and the receiver has
// taken the last result. Synchronous active-high reset clears estimates and
// covariance and loads the noise register defaults.
`default_nettype none
module angle_bias_kalman_filter (
   input  wire logic clock,
   input  wire logic reset,
   abkf_req_if.sink  req,
   abkf_rsp_if.source rsp,
   abkf_csr_if.sink  csr
);
   import abkf_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_M_ANG, S_M_DP11, S_M_P00, S_M_P11, S_DIV0, S_DIV1,
      S_M_A, S_M_B, S_M_C0, S_M_C1, S_M_C2, S_M_C3, S_OUT
   } state_type;

   state_type st_ff;
   noise_type qa_ff, qb_ff, rr_ff;
   val_type ang_ff, bias_ff, urate_ff, z_ff, y_ff;
   cov_type p00_ff, p01_ff, p10_ff, p11_ff, dp11_ff, k0_ff, k1_ff;
   cov_type q00_ff, q01_ff;
   dt_type  dt_ff;
   logic    go_ff;
   logic    rsp_v_ff;
   val_type rsp_d_ff;

   logic signed [47:0] ma, mb;
   logic mdone, ddone;
   logic signed [96:0] mprod;
   logic signed [47:0] dnum, dquot;
   logic signed [48:0] sden;
   logic [95:0] sh16, sh32;
   logic signed [127:0] r16, r32;
   logic signed [127:0] tsum;

   abkf_mul u_mul (.clock, .reset, .start(go_ff && st_ff != S_DIV0 && st_ff != S_DIV1),
                   .op_a(ma), .op_b(mb), .done(mdone), .product(mprod));
   abkf_div u_div (.clock, .reset, .start(go_ff && (st_ff == S_DIV0 || st_ff == S_DIV1)),
                   .num(dnum), .den(sden), .done(ddone), .quot(dquot));

   assign sden = 49'(p00_ff) + 49'(signed'({1'b0, rr_ff}));
   assign dnum = (st_ff == S_DIV0) ? p00_ff : p10_ff;
   // truncate magnitude, then sign
   assign sh16 = mprod[95:0] >> 16;
   assign sh32 = mprod[95:0] >> 32;
   assign r16 = mprod[96] ? -$signed({32'd0, sh16}) : $signed({32'd0, sh16});
   assign r32 = mprod[96] ? -$signed({32'd0, sh32}) : $signed({32'd0, sh32});
   assign tsum = 128'(dp11_ff) - 128'(p01_ff) - 128'(p10_ff) + $signed({96'd0, qa_ff});

   always_comb begin
      ma = '0; mb = '0;
      case (st_ff)
         S_M_ANG:  begin ma = 48'(dt_ff); mb = 48'(urate_ff); end
         S_M_DP11: begin ma = 48'(dt_ff); mb = p11_ff; end
         S_M_P00:  begin ma = 48'(dt_ff); mb = sat_cov(tsum); end
         S_M_P11:  begin ma = 48'(qb_ff); mb = 48'(dt_ff); end
         S_M_A:    begin ma = k0_ff; mb = 48'(y_ff); end
         S_M_B:    begin ma = k1_ff; mb = 48'(y_ff); end
         S_M_C0:   begin ma = k0_ff; mb = q00_ff; end
         S_M_C1:   begin ma = k0_ff; mb = q01_ff; end
         S_M_C2:   begin ma = k1_ff; mb = q00_ff; end
         S_M_C3:   begin ma = k1_ff; mb = q01_ff; end
         default:  begin ma = '0; mb = '0; end
      endcase
   end

   assign req.ready = (st_ff == S_IDLE) && !rsp_v_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_v_ff;
   assign rsp.filtered_angle = rsp_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; go_ff <= 1'b0; rsp_v_ff <= 1'b0;
         qa_ff <= 32'd4294967; qb_ff <= 32'd12884902; rr_ff <= 32'd128849019;
         ang_ff <= '0; bias_ff <= '0; urate_ff <= '0;
         p00_ff <= '0; p01_ff <= '0; p10_ff <= '0; p11_ff <= '0;
      end else begin
         go_ff <= 1'b0;
         if (rsp_v_ff && rsp.ready) rsp_v_ff <= 1'b0;
         if (csr.valid) begin
            unique case (csr_idx_type'(csr.index))
               CSR_ANGLE_Q: qa_ff <= csr.data;
               CSR_BIAS_Q:  qb_ff <= csr.data;
               CSR_MEAS_R:  rr_ff <= csr.data;
               CSR_UNUSED:  ;
            endcase
         end
         unique case (st_ff)
            S_IDLE: if (req.valid && req.ready) begin
               z_ff <= req.measured_angle; dt_ff <= req.time_step;
               urate_ff <= sat_val(128'(req.measured_rate) - 128'(bias_ff));
               st_ff <= S_M_ANG; go_ff <= 1'b1;
            end
            S_M_ANG: if (mdone) begin
               ang_ff <= sat_val(128'(ang_ff) + 128'(sat_val(r16)));
               st_ff <= S_M_DP11; go_ff <= 1'b1;
            end
            S_M_DP11: if (mdone) begin
               dp11_ff <= sat_cov(r16); st_ff <= S_M_P00; go_ff <= 1'b1;
            end
            S_M_P00: if (mdone) begin
               p00_ff <= sat_cov(128'(p00_ff) + 128'(sat_cov(r16)));
               p01_ff <= sat_cov(128'(p01_ff) - 128'(dp11_ff));
               p10_ff <= sat_cov(128'(p10_ff) - 128'(dp11_ff));
               y_ff <= sat_val(128'(z_ff) - 128'(ang_ff));
               st_ff <= S_M_P11; go_ff <= 1'b1;
            end
            S_M_P11: if (mdone) begin
               p11_ff <= sat_cov(128'(p11_ff) + 128'(sat_cov(r16)));
               q00_ff <= p00_ff; q01_ff <= p01_ff;
               if (sden == '0) begin
                  // zero variance: gains are set to zero
                  k0_ff <= '0; k1_ff <= '0; st_ff <= S_M_A;
               end else st_ff <= S_DIV0;
               go_ff <= 1'b1;
            end
            S_DIV0: if (ddone) begin
               k0_ff <= dquot; st_ff <= S_DIV1; go_ff <= 1'b1;
            end
            S_DIV1: if (ddone) begin
               k1_ff <= dquot; st_ff <= S_M_A; go_ff <= 1'b1;
            end
            S_M_A: if (mdone) begin
               ang_ff <= sat_val(128'(ang_ff) + 128'(sat_val(r32)));
               st_ff <= S_M_B; go_ff <= 1'b1;
            end
            S_M_B: if (mdone) begin
               bias_ff <= sat_val(128'(bias_ff) + 128'(sat_val(r32)));
               st_ff <= S_M_C0; go_ff <= 1'b1;
            end
            S_M_C0: if (mdone) begin
               p00_ff <= sat_cov(128'(q00_ff) - 128'(sat_cov(r32)));
               st_ff <= S_M_C1; go_ff <= 1'b1;
            end
            S_M_C1: if (mdone) begin
               p01_ff <= sat_cov(128'(q01_ff) - 128'(sat_cov(r32)));
               st_ff <= S_M_C2; go_ff <= 1'b1;
            end
            S_M_C2: if (mdone) begin
               p10_ff <= sat_cov(128'(p10_ff) - 128'(sat_cov(r32)));
               st_ff <= S_M_C3; go_ff <= 1'b1;
            end
            S_M_C3: if (mdone) begin
               p11_ff <= sat_cov(128'(p11_ff) - 128'(sat_cov(r32)));
               st_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_v_ff <= 1'b1; rsp_d_ff <= ang_ff; st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> !req.ready) else $error("accept while busy");
   a_out_once: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_OUT) |=> rsp_v_ff) else $error("result not posted");
   a_go_pulse: assert property (@(posedge clock) disable iff (reset)
      go_ff |=> !go_ff) else $error("start held");
endmodule
`default_nettype wire

// ----- sim/angle_bias_kalman_filter_tb.sv -----
// Testbench for angle_bias_kalman_filter: drives fused IMU samples, predicts each
// filtered angle with a fixed-point filter model and checks it. Depends on
// abkf_pkg, the channel interfaces in abkf_if.sv and the filter itself.
`timescale 1ns / 100ps
`default_nettype none
module angle_bias_kalman_filter_tb;
   import abkf_pkg::*;

   localparam int CycleLimit = 6_000_000;
   localparam int DrainCycles = 1000;

   logic clock;
   logic reset;
   int   cycle_count;
   int   error_count;
   int   stall_left;
   bit   long_hold;

   abkf_req_if req ();
   abkf_rsp_if rsp ();
   abkf_csr_if csr ();

   angle_bias_kalman_filter uut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   // Filter model state
   longint angle_noise, bias_noise, meas_noise;
   longint est_angle, est_bias, est_rate;
   longint cov [4];
   val_type expected_angles [$];

   function automatic longint clamp(longint v, int w);
      longint lim;
      lim = longint'(1) << (w - 1);
      if (v > lim - 1) return lim - 1;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic logic [63:0] magnitude(longint x);
      logic [63:0] r;
      r = x;
      if (x < 0) r = -r;
      return r;
   endfunction

   function automatic longint limit_signed(bit neg, logic [127:0] m, int w);
      logic [127:0] lim;
      lim = 128'd1 << (w - 1);
      if (m > lim - 1 + neg) return neg ? -longint'(lim[63:0]) : longint'(lim[63:0] - 1);
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   function automatic longint scaled_product(longint a, longint b, int sh, int w);
      logic [127:0] p;
      p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      p = p >> sh;
      return limit_signed((a < 0) != (b < 0), p, w);
   endfunction

   function automatic longint gain_quotient(longint num, longint den);
      logic [127:0] q;
      q = ({64'd0, magnitude(num)} << 32) / {64'd0, magnitude(den)};
      return limit_signed((num < 0) != (den < 0), q, CovBits);
   endfunction

   function automatic val_type filter_update(val_type z, val_type r, dt_type dt_in);
      longint dt, p00, p01, p10, p11, dp11, t, s, k0, k1, y;
      dt = longint'(dt_in);
      p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
      est_rate = clamp(longint'(r) - est_bias, ValBits);
      est_angle = clamp(est_angle + scaled_product(dt, est_rate, 16, ValBits), ValBits);
      dp11 = scaled_product(dt, p11, 16, CovBits);
      t = clamp(dp11 - p01 - p10 + angle_noise, CovBits);
      p00 = clamp(p00 + scaled_product(dt, t, 16, CovBits), CovBits);
      p01 = clamp(p01 - dp11, CovBits);
      p10 = clamp(p10 - dp11, CovBits);
      p11 = clamp(p11 + scaled_product(bias_noise, dt, 16, CovBits), CovBits);
      s = p00 + meas_noise;
      k0 = 0;
      k1 = 0;
      if (s != 0) begin
         k0 = gain_quotient(p00, s);
         k1 = gain_quotient(p10, s);
      end
      y = clamp(longint'(z) - est_angle, ValBits);
      est_angle = clamp(est_angle + scaled_product(k0, y, 32, ValBits), ValBits);
      est_bias = clamp(est_bias + scaled_product(k1, y, 32, ValBits), ValBits);
      cov[0] = clamp(p00 - scaled_product(k0, p00, 32, CovBits), CovBits);
      cov[1] = clamp(p01 - scaled_product(k0, p01, 32, CovBits), CovBits);
      cov[2] = clamp(p10 - scaled_product(k1, p00, 32, CovBits), CovBits);
      cov[3] = clamp(p11 - scaled_product(k1, p01, 32, CovBits), CovBits);
      return val_type'(est_angle[31:0]);
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_angles.size() == 0) begin
            $display("%0t: unexpected word, actual %h", $time, rsp.filtered_angle);
            error_count++;
         end else begin
            if (rsp.filtered_angle !== expected_angles[0]) begin
               $display("%0t: filtered_angle mismatch, expected %h actual %h",
                        $time, expected_angles[0], rsp.filtered_angle);
               error_count++;
            end
            void'(expected_angles.pop_front());
         end
      end
   end

   // Receiver stalls: mostly short, a few long, plus a requested long hold
   always @(negedge clock) begin
      if (long_hold) begin
         long_hold = 1'b0;
         stall_left = 3000;
      end
      if (stall_left > 0) begin
         rsp.ready = 1'b0;
         stall_left--;
      end else begin
         rsp.ready = 1'b1;
         if ($urandom_range(0, 15) == 0)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                     : $urandom_range(1, 4);
      end
   end

   task automatic send_sample(val_type z, val_type r, dt_type dt, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                       : $urandom_range(0, 3));
      if (gap > 0) begin
         @(negedge clock);
         req.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req.valid = 1'b1;
      req.measured_angle = z;
      req.measured_rate = r;
      req.time_step = dt;
      do @(posedge clock); while (!req.ready);
      expected_angles.push_back(filter_update(z, r, dt));
   endtask

   task automatic drain;
      @(negedge clock);
      req.valid = 1'b0;
      while (expected_angles.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [31:0] value);
      @(negedge clock);
      csr.valid = 1'b1;
      csr.index = idx;
      csr.data = value;
      do @(posedge clock); while (!csr.ready);
      case (idx)
         CSR_ANGLE_Q: angle_noise = longint'(value);
         CSR_BIAS_Q:  bias_noise = longint'(value);
         CSR_MEAS_R:  meas_noise = longint'(value);
         default: ;
      endcase
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   task automatic set_noise(logic [31:0] q_angle, logic [31:0] q_bias, logic [31:0] r_meas);
      drain();
      write_csr(CSR_ANGLE_Q, q_angle);
      write_csr(CSR_BIAS_Q, q_bias);
      write_csr(CSR_MEAS_R, r_meas);
   endtask

   function automatic val_type random_value();
      case ($urandom_range(0, 4))
         0: return val_type'($urandom);
         1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return val_type'($signed($urandom_range(0, 6_000_000)) - 3_000_000);
      endcase
   endfunction

   function automatic dt_type random_step();
      case ($urandom_range(0, 5))
         0: return dt_type'($urandom);
         1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return dt_type'($urandom_range(60, 1400));
      endcase
   endfunction

   // Zero innovation variance first, while the covariance is still clear
   task automatic test_directed;
      set_noise(32'h0, 32'h0, 32'h0);
      send_sample(32'sh0001_0000, 32'sh0000_8000, 16'h0000);
      send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 16'h0000);
      drain();
      write_csr(CSR_UNUSED, 32'hFFFF_FFFF);
      set_noise(32'd4294967, 32'd12884902, 32'd128849019);
      send_sample(32'sh0000_0000, 32'sh0000_0000, 16'h0000);
      send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF);
      send_sample(32'sh8000_0000, 32'sh8000_0000, 16'hFFFF);
      send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 16'h0001);
      send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 16'h8000);
      send_sample(32'shFFFF_FFFF, 32'sh0000_0001, 16'd655);
      send_sample(32'sh0005_0000, 32'sh0001_0000, 16'd655);
      set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      repeat (6) send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF);
      repeat (4) send_sample(32'sh8000_0000, 32'sh8000_0000, 16'hFFFF);
      set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      repeat (4) send_sample(random_value(), random_value(), 16'hFFFF);
   endtask

   task automatic test_random(int count);
      repeat (count) send_sample(random_value(), random_value(), random_step());
   endtask

   task automatic test_noise_settings;
      set_noise(32'd4294967, 32'd12884902, 32'd128849019);
      test_random(400);
      set_noise($urandom, $urandom, $urandom);
      test_random(300);
      set_noise(32'h0, 32'h0, 32'h0);
      test_random(150);
      set_noise(32'hFFFF_FFFF, 32'h0, 32'h1);
      test_random(150);
      set_noise($urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 32'h00FF_FFFF),
                $urandom_range(0, 32'h0FFF_FFFF));
      test_random(300);
   endtask

   // Hold off the receiver while the sender keeps offering back to back
   task automatic test_backpressure;
      set_noise(32'd4294967, 32'd12884902, 32'd128849019);
      @(negedge clock);
      long_hold = 1'b1;
      repeat (20) send_sample(random_value(), random_value(), random_step(), 1'b1);
   endtask

   initial begin
      cycle_count = 0;
      error_count = 0;
      stall_left = 0;
      long_hold = 1'b0;
      angle_noise = 4294967;
      bias_noise = 12884902;
      meas_noise = 128849019;
      est_angle = 0;
      est_bias = 0;
      est_rate = 0;
      foreach (cov[i]) cov[i] = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.measured_angle = '0;
      req.measured_rate = '0;
      req.time_step = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_noise_settings();
      test_backpressure();
      drain();

      if (error_count == 0 && expected_angles.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
